// ----- sv/terminal_line_editor_top_defines.svh -----
`ifndef TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH

// same-cycle implication
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tle_pkg.sv -----
`default_nettype none

package tle_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int ROW_BYTES     = 8;
    localparam int LANE_W        = 3;
    localparam int STORE_ROWS    = (STORE_DEPTH + ROW_BYTES - 1) / ROW_BYTES;
    localparam int ROW_W         = (LEN_W > LANE_W) ? LEN_W - LANE_W : 1;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [63:0] SEQ_ERASE  = 64'h0000_0000_0008_2008;
    localparam logic [3:0]  CNT_ERASE  = 4'd3;
    localparam logic [63:0] SEQ_CRLF   = 64'h0000_0000_0000_0A0D;
    localparam logic [3:0]  CNT_CRLF   = 4'd2;
    localparam logic [63:0] SEQ_PROMPT = 64'h0000_0000_203E_0A0D;
    localparam logic [3:0]  CNT_PROMPT = 4'd4;

    localparam logic DEST_TERMINAL = 1'b0;
    localparam logic DEST_COMMAND  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CRLF,
        S_READ,
        S_CHUNK,
        S_PROMPT
    } t_state;

    typedef struct packed {
        logic        destination;
        logic [63:0] payload;
        logic [3:0]  byte_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        logic [7:0]        wr_byte;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- sv/tle_ifs.sv -----
`default_nettype none

interface tle_rx_if ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_res_if ();
    logic        valid;
    logic        ready;
    logic        destination;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, output destination, output payload,
                    output byte_count, output last, input ready);
    modport sink   (input valid, input destination, input payload,
                    input byte_count, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/terminal_line_editor_top.sv -----
// channel  dir  fields                                     beat when
// i_rx     in   rx_byte[7:0]                               valid && ready
// o_res    out  destination, payload[63:0], byte_count, last  valid && ready
//
// a byte is taken, decoded, held on output stalls; echo and backspace give one beat
// a line end gives crlf if nonempty, a read and beat per 8-char row, then the prompt
// the row walk is bound by the single registered read port of the line ram
// reset clears length, cr flag and output valid; line ram contents are not cleared
// the next byte is taken while the last beat of the previous one still waits
`default_nettype none

`include "terminal_line_editor_top_defines.svh"

module terminal_line_editor_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tle_rx_if.sink    i_rx,
    tle_res_if.source o_res
);
    import tle_pkg::*;

    t_ram_req    ram_req;
    logic [63:0] rd_data;

    tle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .o_res     (o_res),
        .o_ram_req (ram_req),
        .i_rd_data (rd_data)
    );

    tle_line_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    `TLE_ASSERT_NOW(a_count_range, o_res.valid, (o_res.byte_count != 4'd0) && (o_res.byte_count <= 4'd8), "byte_count out of range")
    `TLE_ASSERT_NOW(a_cmd_not_last, o_res.valid && (o_res.destination == DEST_COMMAND), !o_res.last, "command beat flagged last")
    `TLE_ASSERT_NOW(a_wr_busy, ram_req.wr_en, !i_rx.ready && !ram_req.rd_en, "line write while idle or reading")
    `TLE_ASSERT_NEXT(a_rd_single, ram_req.rd_en, !ram_req.rd_en && !i_rx.ready, "back-to-back row reads")

endmodule

`default_nettype wire

// ----- sv/tle_line_ram.sv -----
`default_nettype none

module tle_line_ram (
    input  wire logic              i_clk,
    input  wire tle_pkg::t_ram_req i_req,
    output logic [63:0]            o_rd_data
);
    import tle_pkg::*;

    logic [63:0] mem [STORE_ROWS];
    logic [63:0] r_rd_data;

    // byte-lane write
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.row][i_req.lane*8 +: 8] <= i_req.wr_byte;
        end
    end

    // registered row read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/tle_ctrl.sv -----
`default_nettype none

module tle_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tle_rx_if.sink                  i_rx,
    tle_res_if.source               o_res,
    output tle_pkg::t_ram_req       o_ram_req,
    input  wire logic [63:0]        i_rd_data
);
    import tle_pkg::*;

    t_state           r_state, n_state;
    logic [7:0]       r_byte;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_cr, n_cr;
    logic             r_out_valid;
    t_result          r_out, n_out;
    logic             load;

    logic             out_free;
    logic             is_lf, is_cr, is_erase, is_print, has_room, len_nz;
    logic             more;
    logic [3:0]       chunk;
    logic [63:0]      chunk_data;

    assign out_free = !r_out_valid || o_res.ready;
    assign is_lf    = (r_byte == CH_LF);
    assign is_cr    = (r_byte == CH_CR);
    assign is_erase = (r_byte == CH_BS) || (r_byte == CH_DEL);
    assign is_print = (r_byte >= CH_SPACE) && (r_byte <= CH_TILDE);
    assign has_room = (r_len < LEN_W'(STORE_DEPTH));
    assign len_nz   = (r_len != '0);
    assign more     = (9'(r_rem) > 9'(ROW_BYTES));
    assign chunk    = more ? 4'(ROW_BYTES) : 4'(r_rem);

    // zero the lanes past the chunk end
    always_comb begin
        for (int i = 0; i < ROW_BYTES; i++) begin
            chunk_data[i*8 +: 8] = (4'(i) < chunk) ? i_rd_data[i*8 +: 8] : 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_rx.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (is_lf && r_cr) begin
                    n_state = S_IDLE;
                end else if (is_cr || is_lf) begin
                    n_state = len_nz ? S_CRLF : S_PROMPT;
                end else if ((is_erase && len_nz) || (is_print && has_room)) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CRLF: begin
                if (out_free) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHUNK;
            end
            S_CHUNK: begin
                if (out_free) begin
                    n_state = more ? S_READ : S_PROMPT;
                end
            end
            S_PROMPT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_len     = r_len;
        n_rem     = r_rem;
        n_row     = r_row;
        n_cr      = r_cr;
        load      = 1'b0;
        n_out     = r_out;
        o_ram_req = '{wr_en: 1'b0, rd_en: 1'b0, row: r_row,
                      lane: LANE_W'(r_len), wr_byte: r_byte};
        case (r_state)
            S_DECODE: begin
                if (is_lf && r_cr) begin
                    n_cr = 1'b0;
                end else if (is_cr || is_lf) begin
                    n_cr  = is_cr;
                    n_rem = r_len;
                    n_row = '0;
                end else begin
                    n_cr = 1'b0;
                    if (is_erase && len_nz && out_free) begin
                        n_len = r_len - 1'b1;
                        load  = 1'b1;
                        n_out = '{destination: DEST_TERMINAL, payload: SEQ_ERASE,
                                  byte_count: CNT_ERASE, last: 1'b1};
                    end else if (is_print && has_room && out_free) begin
                        n_len           = r_len + 1'b1;
                        o_ram_req.wr_en = 1'b1;
                        o_ram_req.row   = ROW_W'(r_len >> LANE_W);
                        load            = 1'b1;
                        n_out = '{destination: DEST_TERMINAL, payload: 64'(r_byte),
                                  byte_count: 4'd1, last: 1'b1};
                    end
                end
            end
            S_CRLF: begin
                if (out_free) begin
                    load  = 1'b1;
                    n_out = '{destination: DEST_TERMINAL, payload: SEQ_CRLF,
                              byte_count: CNT_CRLF, last: 1'b0};
                end
            end
            S_READ: begin
                o_ram_req.rd_en = 1'b1;
            end
            S_CHUNK: begin
                if (out_free) begin
                    load  = 1'b1;
                    n_out = '{destination: DEST_COMMAND, payload: chunk_data,
                              byte_count: chunk, last: 1'b0};
                    n_row = r_row + 1'b1;
                    if (more) begin
                        n_rem = r_rem - LEN_W'(ROW_BYTES);
                    end else begin
                        n_rem = '0;
                        n_len = '0;
                    end
                end
            end
            S_PROMPT: begin
                if (out_free) begin
                    load  = 1'b1;
                    n_out = '{destination: DEST_TERMINAL, payload: SEQ_PROMPT,
                              byte_count: CNT_PROMPT, last: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cr        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cr    <= n_cr;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
        r_rem <= n_rem;
        r_row <= n_row;
        if (load) begin
            r_out <= n_out;
        end
    end

    assign i_rx.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.destination = r_out.destination;
    assign o_res.payload     = r_out.payload;
    assign o_res.byte_count  = r_out.byte_count;
    assign o_res.last        = r_out.last;

endmodule

`default_nettype wire
